[sv/wang_tile_pixel_generator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Wang tile pixel generator
// Concurrent checks on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WANG_TILE_PIXEL_GENERATOR_ASSERT_SVH
`define WANG_TILE_PIXEL_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define WTPG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wtpg assertion failed");
`define WTPG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wtpg assertion failed");
`else
`define WTPG_ASSERT_IMP(lbl, ante, cons)
`define WTPG_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[sv/wtpg_pkg.sv]
// ----------------------------------------------------------------------------
// wtpg_pkg
// Types, constants and table builders shared by the pixel generator.
// ----------------------------------------------------------------------------
package wtpg_pkg;

  localparam int IMAGE_WIDTH  = 512;
  localparam int IMAGE_HEIGHT = 512;
  localparam int COORD_W      = 9;
  localparam int FRAC_W       = 16;
  localparam int CH_W         = FRAC_W + 1;   // 0 .. 1.0 inclusive
  localparam int SIDES        = 4;
  localparam int CHANNELS     = 3;
  localparam int LEVEL_W      = 8;
  localparam int GIDX_W       = 10;

  localparam logic [CH_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [CH_W-1:0] HALF_Q16 = 17'h08000;

  // side midpoints: right, top, left, bottom
  localparam logic [CH_W-1:0] SIDE_X [SIDES] = '{ONE_Q16, HALF_Q16, 17'h0, HALF_Q16};
  localparam logic [CH_W-1:0] SIDE_Y [SIDES] = '{HALF_Q16, 17'h0, HALF_Q16, ONE_Q16};

  // square root: 32-bit radicand, 16 result bits, two bits per stage
  localparam int SQ_W           = 32;
  localparam int ROOT_W         = 16;
  localparam int SQ_STEPS_STAGE = 2;
  localparam int ISQRT_STAGES   = ROOT_W / SQ_STEPS_STAGE;

  // gamma: one result bit per stage of the threshold search
  localparam int GAMMA_STAGES = LEVEL_W;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sq_t;

  typedef logic [GIDX_W:0] gamma_thr_t [256];

  function automatic sq_t sq_step(sq_t a, logic [SQ_W-1:0] b);
    sq_t o;
    logic [SQ_W-1:0] trial;
    trial = a.root + b;
    if (a.rem >= trial) begin
      o.rem  = a.rem - trial;
      o.root = (a.root >> 1) + b;
    end else begin
      o.rem  = a.rem;
      o.root = a.root >> 1;
    end
    return o;
  endfunction

  // smallest table index i with (k/255)^11 <= (i/1024)^5, 1024 when none
  function automatic gamma_thr_t gamma_thr_build();
    gamma_thr_t tab;
    logic [159:0] lhs;
    logic [159:0] rhs;
    int lo;
    int hi;
    int mid;
    for (int k = 0; k < 256; k++) begin
      lhs = 160'd1;
      for (int e = 0; e < 11; e++) lhs = lhs * 160'(k);
      lhs = lhs << 50;
      lo = 0;
      hi = 1024;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        rhs = 160'd1;
        for (int e = 0; e < 11; e++) rhs = rhs * 160'd255;
        for (int e = 0; e < 5; e++) rhs = rhs * 160'(mid);
        if (lhs <= rhs) hi = mid;
        else lo = mid + 1;
      end
      tab[k] = (GIDX_W+1)'(lo);
    end
    return tab;
  endfunction

  localparam gamma_thr_t GAMMA_THR = gamma_thr_build();

endpackage

[sv/wtpg_ifs.sv]
// ----------------------------------------------------------------------------
// Stream interfaces
// Pixel coordinate words in, RGB words out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wtpg_pix_if;
  logic       valid;
  logic       ready;
  logic [8:0] pixel_x;
  logic [8:0] pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface wtpg_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

[sv/wang_tile_pixel_generator.sv]
// Pipeline: distance, square, square root, blend, gamma, then the RGB word.
// Throughput: one pixel per cycle; the square root and gamma search are
// fully pipelined, and an output stall freezes every stage at once.
// Reset (rst_n, synchronous) clears all valid bits and sets mask_r to 15.
// ----------------------------------------------------------------------------
// wang_tile_pixel_generator
// Wang tile shader: distance to side midpoints, blend, gamma, 8-bit RGB.
// ----------------------------------------------------------------------------
`include "wang_tile_pixel_generator_assert.svh"

module wang_tile_pixel_generator (
  input  logic              clk,
  input  logic              rst_n,
  wtpg_pix_if.sink          in_pix,
  wtpg_rgb_if.source        out_rgb,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata
);
  import wtpg_pkg::*;

  localparam int ST_SQ    = 1;
  localparam int ST_BLEND = ST_SQ + ISQRT_STAGES + 1;
  localparam int DEPTH    = ST_BLEND + SIDES + GAMMA_STAGES;

  logic             en;
  logic [3:0]       mask_r;
  logic [DEPTH-1:0] vld_r;

  assign en           = !out_rgb.valid || out_rgb.ready;
  assign in_pix.ready = en;
  assign out_rgb.valid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 4'hF;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_pix.valid};
    end
  end

  // stage 0: scale and take distances to the midpoints
  logic [COORD_W+FRAC_W-1:0] ux_full;
  logic [COORD_W+FRAC_W-1:0] vy_full;
  logic [CH_W-1:0]           dxa_nxt [SIDES];
  logic [CH_W-1:0]           dya_nxt [SIDES];
  logic [CH_W-1:0]           dxa_r   [SIDES];
  logic [CH_W-1:0]           dya_r   [SIDES];
  logic [3:0]                mask_a_r;

  assign ux_full = (COORD_W+FRAC_W)'({in_pix.pixel_x, {FRAC_W{1'b0}}} / IMAGE_WIDTH);
  assign vy_full = (COORD_W+FRAC_W)'({in_pix.pixel_y, {FRAC_W{1'b0}}} / IMAGE_HEIGHT);

  always_comb begin
    logic signed [CH_W:0] dx;
    logic signed [CH_W:0] dy;
    for (int s = 0; s < SIDES; s++) begin
      dx = $signed({1'b0, SIDE_X[s]}) - $signed({1'b0, ux_full[CH_W-1:0]});
      dy = $signed({1'b0, SIDE_Y[s]}) - $signed({1'b0, vy_full[CH_W-1:0]});
      dxa_nxt[s] = dx[CH_W] ? CH_W'(-dx) : dx[CH_W-1:0];
      dya_nxt[s] = dy[CH_W] ? CH_W'(-dy) : dy[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dxa_r    <= dxa_nxt;
      dya_r    <= dya_nxt;
      mask_a_r <= mask_r;
    end
  end

  // stage 1: squared distance
  logic [2*CH_W-1:0] sq_r [SIDES];
  logic [3:0]        mask_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < SIDES; s++) begin
        sq_r[s] <= (2*CH_W)'(dxa_r[s] * dxa_r[s]) + (2*CH_W)'(dya_r[s] * dya_r[s]);
      end
      mask_b_r <= mask_a_r;
    end
  end

  // root of 4*d2; anything at or past 2^32 saturates to a full distance
  logic [SIDES-1:0][SQ_W-1:0]   rad;
  logic [SIDES-1:0]             sat;
  logic [SIDES-1:0][ROOT_W-1:0] root;
  logic [SIDES-1:0]             sat_c;
  logic [3:0]                   mask_c;

  always_comb begin
    for (int s = 0; s < SIDES; s++) begin
      rad[s] = {sq_r[s][SQ_W-3:0], 2'b00};
      sat[s] = |sq_r[s][2*CH_W-1:SQ_W-2];
    end
  end

  wtpg_isqrt #(
    .LANES  (SIDES),
    .SIDE_W (SIDES + 4)
  ) u_isqrt (
    .clk      (clk),
    .en       (en),
    .rad_in   (rad),
    .side_in  ({mask_b_r, sat}),
    .root_out (root),
    .side_out ({mask_c, sat_c})
  );

  logic [CH_W-1:0] t_c [SIDES];

  always_comb begin
    for (int s = 0; s < SIDES; s++) begin
      t_c[s] = sat_c[s] ? '0 : ONE_Q16 - {1'b0, root[s]};
    end
  end

  // blend stages, one side each
  logic [CH_W-1:0] bl_ch_r   [SIDES][CHANNELS];
  logic [CH_W-1:0] bl_t_r    [SIDES-1][SIDES];
  logic [3:0]      bl_mask_r [SIDES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      // from black, the first blend lands on the target times t
      bl_ch_r[0][0] <= mask_c[0] ? '0 : t_c[0];
      bl_ch_r[0][1] <= mask_c[0] ? t_c[0] : '0;
      bl_ch_r[0][2] <= mask_c[0] ? t_c[0] : '0;
      bl_t_r[0]     <= t_c;
      bl_mask_r[0]  <= mask_c;
    end
  end

  for (genvar k = 1; k < SIDES; k++) begin : g_blend
    logic [CH_W-1:0] ch_nxt [CHANNELS];

    always_comb begin
      logic [2*CH_W-1:0] prod;
      logic [CH_W-1:0]   t;
      logic              cyan;
      logic              up;
      t    = bl_t_r[k-1][k];
      cyan = bl_mask_r[k-1][k];
      for (int c = 0; c < CHANNELS; c++) begin
        prod      = bl_ch_r[k-1][c] * (ONE_Q16 - t);
        up        = (c == 0) ? !cyan : cyan;
        ch_nxt[c] = CH_W'(prod >> FRAC_W) + (up ? t : '0);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        bl_ch_r[k] <= ch_nxt;
      end
    end

    // advance t and mask alongside the channels
    if (k < SIDES - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          bl_t_r[k]    <= bl_t_r[k-1];
          bl_mask_r[k] <= bl_mask_r[k-1];
        end
      end
    end
  end

  // gamma
  logic [CHANNELS-1:0][GIDX_W-1:0]  g_idx;
  logic [CHANNELS-1:0]              g_full;
  logic [CHANNELS-1:0][LEVEL_W-1:0] level;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      g_idx[c]  = bl_ch_r[SIDES-1][c][FRAC_W-1:FRAC_W-GIDX_W];
      g_full[c] = bl_ch_r[SIDES-1][c][FRAC_W];
    end
  end

  wtpg_gamma #(
    .LANES (CHANNELS)
  ) u_gamma (
    .clk       (clk),
    .en        (en),
    .idx_in    (g_idx),
    .full_in   (g_full),
    .level_out (level)
  );

  assign out_rgb.red   = level[0];
  assign out_rgb.green = level[1];
  assign out_rgb.blue  = level[2];

  logic blend_ok;
  assign blend_ok = (bl_ch_r[SIDES-1][0] <= ONE_Q16) && (bl_ch_r[SIDES-1][1] <= ONE_Q16) &&
                    (bl_ch_r[SIDES-1][2] <= ONE_Q16);

  `WTPG_ASSERT_IMP(a_blend_range, vld_r[ST_BLEND+SIDES-1], blend_ok)
  `WTPG_ASSERT_IMP(a_green_blue, out_rgb.valid, out_rgb.green == out_rgb.blue)
  `WTPG_ASSERT_NXT(a_stall_hold, !en, $stable(vld_r))

endmodule

[sv/wtpg_isqrt.sv]
// ----------------------------------------------------------------------------
// wtpg_isqrt
// Pipelined integer square root over several lanes, with a sideband word.
// ----------------------------------------------------------------------------
module wtpg_isqrt #(
  parameter int LANES  = 4,
  parameter int SIDE_W = 1
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [LANES-1:0][wtpg_pkg::SQ_W-1:0]  rad_in,
  input  logic [SIDE_W-1:0]                     side_in,
  output logic [LANES-1:0][wtpg_pkg::ROOT_W-1:0] root_out,
  output logic [SIDE_W-1:0]                     side_out
);
  import wtpg_pkg::*;

  sq_t               st_r   [ISQRT_STAGES][LANES];
  logic [SIDE_W-1:0] side_r [ISQRT_STAGES];

  for (genvar s = 0; s < ISQRT_STAGES; s++) begin : g_stage
    sq_t st_nxt [LANES];

    always_comb begin
      sq_t cur;
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          cur.rem  = rad_in[l];
          cur.root = '0;
        end else begin
          cur = st_r[(s == 0) ? 0 : s-1][l];
        end
        for (int j = 0; j < SQ_STEPS_STAGE; j++) begin
          cur = sq_step(cur, SQ_W'(1) << (SQ_W - 2 - 2*(s*SQ_STEPS_STAGE + j)));
        end
        st_nxt[l] = cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) st_r[s][l] <= st_nxt[l];
        side_r[s] <= (s == 0) ? side_in : side_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      root_out[l] = st_r[ISQRT_STAGES-1][l].root[ROOT_W-1:0];
    end
  end
  assign side_out = side_r[ISQRT_STAGES-1];

endmodule

[sv/wtpg_gamma.sv]
// ----------------------------------------------------------------------------
// wtpg_gamma
// Pipelined gamma lookup: binary search over the level thresholds.
// ----------------------------------------------------------------------------
module wtpg_gamma #(
  parameter int LANES = 3
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [LANES-1:0][wtpg_pkg::GIDX_W-1:0] idx_in,
  input  logic [LANES-1:0]                       full_in,
  output logic [LANES-1:0][wtpg_pkg::LEVEL_W-1:0] level_out
);
  import wtpg_pkg::*;

  logic [LANES-1:0][LEVEL_W-1:0] lvl_r  [GAMMA_STAGES];
  logic [LANES-1:0][GIDX_W-1:0]  idx_r  [GAMMA_STAGES];
  logic [LANES-1:0]              full_r [GAMMA_STAGES];

  for (genvar s = 0; s < GAMMA_STAGES; s++) begin : g_stage
    logic [LANES-1:0][LEVEL_W-1:0] lvl_nxt;
    logic [LANES-1:0][GIDX_W-1:0]  idx_cur;
    logic [LANES-1:0]              full_cur;

    always_comb begin
      logic [LEVEL_W-1:0] prev;
      logic [LEVEL_W-1:0] cand;
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          prev        = '0;
          idx_cur[l]  = idx_in[l];
          full_cur[l] = full_in[l];
        end else begin
          prev        = lvl_r[(s == 0) ? 0 : s-1][l];
          idx_cur[l]  = idx_r[(s == 0) ? 0 : s-1][l];
          full_cur[l] = full_r[(s == 0) ? 0 : s-1][l];
        end
        cand = prev | (LEVEL_W'(1) << (LEVEL_W - 1 - s));
        lvl_nxt[l] = (GAMMA_THR[cand] <= {1'b0, idx_cur[l]}) ? cand : prev;
        // full scale skips the table
        if (s == GAMMA_STAGES - 1 && full_cur[l]) lvl_nxt[l] = '1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lvl_r[s]  <= lvl_nxt;
        idx_r[s]  <= idx_cur;
        full_r[s] <= full_cur;
      end
    end
  end

  assign level_out = lvl_r[GAMMA_STAGES-1];

endmodule
